@@ rtl/satlb_pkg.sv @@
// Package for the set-associative TLB: field widths, defaults, operation codes.
// No dependencies; used by the TLB top level.
`default_nettype none

package satlb_pkg;

    localparam int VADDR_W   = 48;
    localparam int PPN_W     = 40;
    localparam int PAGE_BITS = 12;
    localparam int PADDR_W   = 52;
    localparam int OP_W      = 2;

    localparam int LFSR_W = 16;
    localparam logic [LFSR_W-1:0] LFSR_SEED = 16'hACE1;

    localparam int INDEX_BITS_DEF = 4;
    localparam int WAYS_DEF       = 8;

    typedef enum logic [OP_W-1:0] {
        OP_LOOKUP = 2'd0,
        OP_FILL   = 2'd1,
        OP_FLUSH  = 2'd2
    } op_t;

endpackage

`default_nettype wire

@@ rtl/satlb_row_ram.sv @@
// Single-port-write, single-port-read set row memory with registered read data.
// Generic; no package dependencies. Used by the TLB top level.
`default_nettype none

module satlb_row_ram #(
    parameter int DEPTH  = 16,
    parameter int ADDR_W = 4,
    parameter int DATA_W = 576
) (
    input  wire logic              aclk,
    input  wire logic              rd_en,
    input  wire logic [ADDR_W-1:0] rd_addr,
    output logic      [DATA_W-1:0] rd_data,
    input  wire logic              wr_en,
    input  wire logic [ADDR_W-1:0] wr_addr,
    input  wire logic [DATA_W-1:0] wr_data
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

@@ rtl/set_associative_tlb_unit.sv @@
// Top level of the set-associative TLB with LFSR victim replacement.
// Depends on satlb_pkg and satlb_row_ram.
//
//  channel  | direction | tdata                          | tuser
//  ---------+-----------+--------------------------------+-------------
//  s_       | in        | vaddr[47:0], fill_ppn[87:48]   | op[1:0]
//  m_       | out       | paddr[51:0], zero pad [55:52]  | hit[0]
//
// Each transaction first reads the set row from the row RAM, then compares,
// updates the row and valid bits, and loads the output register.
// A new transaction is taken the cycle after the previous one finishes.
// Reset clears all valid bits and loads the LFSR; tags and ppns are not cleared.
// A full output register stalls the compare stage until m_tready frees it.
`default_nettype none

module set_associative_tlb_unit #(
    parameter int INDEX_BITS = satlb_pkg::INDEX_BITS_DEF,
    parameter int WAYS       = satlb_pkg::WAYS_DEF
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [87:0] s_tdata,  // vaddr[47:0], fill_ppn[87:48]
    input  wire logic [1:0]  s_tuser,  // op[1:0]
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [55:0]      m_tdata,  // paddr[51:0], zero pad
    output logic             m_tuser   // hit
);

    localparam int VADDR_W   = satlb_pkg::VADDR_W;
    localparam int PPN_W     = satlb_pkg::PPN_W;
    localparam int PAGE_BITS = satlb_pkg::PAGE_BITS;
    localparam int PADDR_W   = satlb_pkg::PADDR_W;
    localparam int LFSR_W    = satlb_pkg::LFSR_W;

    localparam int NUM_SETS = 1 << INDEX_BITS;
    localparam int SET_W    = (INDEX_BITS > 0) ? INDEX_BITS : 1;
    localparam int WAY_W    = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam int TAG_LSB  = PAGE_BITS + INDEX_BITS;
    localparam int TAG_W    = VADDR_W - TAG_LSB;
    localparam int ENTRY_W  = TAG_W + PPN_W;
    localparam int ROW_W    = ENTRY_W * WAYS;

    localparam logic [63:0] RECIP_FULL = 64'h1_0000_0000 / WAYS;
    localparam logic [32:0] RECIP      = RECIP_FULL[32:0];
    localparam int PROD_W = LFSR_W + 33;

    // input decode
    logic              s_fire;
    logic [VADDR_W-1:0] s_vaddr;
    logic [PPN_W-1:0]   s_ppn;
    logic [SET_W-1:0]   s_set;

    assign s_vaddr = s_tdata[VADDR_W-1:0];
    assign s_ppn   = s_tdata[VADDR_W +: PPN_W];

    generate
        if (INDEX_BITS > 0) begin : g_idx
            assign s_set = s_vaddr[PAGE_BITS +: SET_W];
        end else begin : g_noidx
            assign s_set = '0;
        end
    endgenerate

    // pipeline registers
    logic                busy_reg;
    logic [1:0]          op_reg;
    logic [VADDR_W-1:0]  vaddr_reg;
    logic [PPN_W-1:0]    ppn_reg;
    logic [SET_W-1:0]    set_reg;
    logic [NUM_SETS-1:0][WAYS-1:0] valid_reg;
    logic [NUM_SETS-1:0][WAYS-1:0] valid_next;
    logic [LFSR_W-1:0]   lfsr_reg;
    logic [LFSR_W-1:0]   lfsr_next;
    logic [LFSR_W-1:0]   quot_reg;
    logic                m_tvalid_reg;
    logic                hit_reg;
    logic [PADDR_W-1:0]  paddr_reg;

    logic                out_free;
    logic                done;

    assign out_free = !m_tvalid_reg || m_tready;
    assign done     = busy_reg && out_free;
    assign s_tready = !busy_reg;
    assign s_fire   = s_tvalid && s_tready;

    // row memory
    logic [ROW_W-1:0] rd_row;
    logic [ROW_W-1:0] wr_row;
    logic             wr_en;

    satlb_row_ram #(
        .DEPTH  (NUM_SETS),
        .ADDR_W (SET_W),
        .DATA_W (ROW_W)
    ) u_row_ram (
        .aclk    (aclk),
        .rd_en   (s_fire),
        .rd_addr (s_set),
        .rd_data (rd_row),
        .wr_en   (wr_en),
        .wr_addr (set_reg),
        .wr_data (wr_row)
    );

    // compare and update
    logic [TAG_W-1:0]  cur_tag;
    logic [WAYS-1:0]   row_valid;
    logic [WAYS-1:0]   match;
    logic              any_match;
    logic [PPN_W-1:0]  hit_ppn;
    logic              any_invalid;
    logic [WAY_W-1:0]  free_way;
    logic [WAY_W-1:0]  victim_way;
    logic [WAY_W-1:0]  fill_way;
    logic [LFSR_W-1:0] rem_diff;
    logic [LFSR_W-1:0] rem_fix;
    logic [PROD_W-1:0] quot_prod;
    logic              lfsr_fb;
    logic              is_lookup;
    logic              is_fill;
    logic              is_flush;

    assign cur_tag     = vaddr_reg[VADDR_W-1:TAG_LSB];
    assign row_valid   = valid_reg[set_reg];
    assign any_invalid = !(&row_valid);
    assign is_lookup   = (op_reg == satlb_pkg::OP_LOOKUP);
    assign is_fill     = (op_reg == satlb_pkg::OP_FILL);
    assign is_flush    = (op_reg == satlb_pkg::OP_FLUSH);

    always_comb begin
        match     = '0;
        any_match = 1'b0;
        hit_ppn   = '0;
        for (int w = 0; w < WAYS; w++) begin
            match[w] = row_valid[w] && (rd_row[w*ENTRY_W +: TAG_W] == cur_tag);
        end
        for (int w = WAYS - 1; w >= 0; w--) begin
            if (match[w]) begin
                any_match = 1'b1;
                hit_ppn   = rd_row[w*ENTRY_W + TAG_W +: PPN_W];
            end
        end
    end

    always_comb begin
        free_way = '0;
        for (int w = 0; w < WAYS; w++) begin
            if (!row_valid[w]) begin
                free_way = WAY_W'(w);
            end
        end
    end

    // victim = lfsr mod WAYS from a registered reciprocal quotient
    assign quot_prod  = PROD_W'(lfsr_reg) * PROD_W'(RECIP);
    assign rem_diff   = lfsr_reg - LFSR_W'(quot_reg * LFSR_W'(WAYS));
    assign rem_fix    = (rem_diff >= LFSR_W'(WAYS)) ? rem_diff - LFSR_W'(WAYS) : rem_diff;
    assign victim_way = rem_fix[WAY_W-1:0];
    assign fill_way   = any_invalid ? free_way : victim_way;

    assign lfsr_fb = lfsr_reg[0] ^ lfsr_reg[2] ^ lfsr_reg[3] ^ lfsr_reg[5];

    always_comb begin
        wr_row = rd_row;
        for (int w = 0; w < WAYS; w++) begin
            if (fill_way == WAY_W'(w)) begin
                wr_row[w*ENTRY_W +: ENTRY_W] = {ppn_reg, cur_tag};
            end
        end
    end

    assign wr_en = done && is_fill;

    always_comb begin
        valid_next = valid_reg;
        lfsr_next  = lfsr_reg;
        if (done) begin
            if (is_fill) begin
                for (int w = 0; w < WAYS; w++) begin
                    if (fill_way == WAY_W'(w)) begin
                        valid_next[set_reg][w] = 1'b1;
                    end
                end
                if (!any_invalid) begin
                    lfsr_next = {lfsr_fb, lfsr_reg[LFSR_W-1:1]};
                end
            end else if (is_flush) begin
                valid_next = '0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg     <= 1'b0;
            valid_reg    <= '0;
            lfsr_reg     <= satlb_pkg::LFSR_SEED;
            m_tvalid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
            lfsr_reg  <= lfsr_next;
            if (s_fire) begin
                busy_reg <= 1'b1;
            end else if (done) begin
                busy_reg <= 1'b0;
            end
            if (done) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        quot_reg <= quot_prod[32 +: LFSR_W];
        if (s_fire) begin
            op_reg    <= s_tuser;
            vaddr_reg <= s_vaddr;
            ppn_reg   <= s_ppn;
            set_reg   <= s_set;
        end
        if (done) begin
            hit_reg   <= is_lookup && any_match;
            paddr_reg <= (is_lookup && any_match) ?
                         {hit_ppn, vaddr_reg[PAGE_BITS-1:0]} : '0;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = hit_reg;
    assign m_tdata  = {4'b0, paddr_reg};

endmodule

`default_nettype wire
